[sv/bir_pkg.sv]
package bir_pkg;

    // fixed field widths
    localparam int CNT_W  = 14;
    localparam int POS_W  = 32;
    localparam int FRAC   = 16;
    localparam int PIX_W  = 24;
    localparam int STEP_W = 21;
    localparam int DIM_W  = 12;
    localparam int NCNT_W = 4;
    localparam int CELL_N = 8;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 21;

    localparam logic [FRAC:0] ONE_FIX = (FRAC+1)'(1) << FRAC;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_SRC_W  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SRC_H  = 3'd1;
    localparam logic [IDX_W-1:0] REG_DST_W  = 3'd2;
    localparam logic [IDX_W-1:0] REG_DST_H  = 3'd3;
    localparam logic [IDX_W-1:0] REG_STEP_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_STEP_Y = 3'd5;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [STEP_W-1:0] t_step;
    typedef logic [NCNT_W-1:0] t_ncnt;

    // clamped configuration seen by front and back
    typedef struct packed {
        t_cnt  src_w;
        t_cnt  src_h;
        t_cnt  dst_w;
        t_cnt  dst_h;
        t_step step_x;
        t_step step_y;
    } t_cfg;

    // one completed cell handed from front to back
    typedef struct packed {
        t_cnt  base_x;
        t_cnt  base_y;
        t_cnt  col_first;
        t_cnt  row_first;
        t_pos  col_pos;
        t_pos  row_pos;
        t_pix  ul;
        t_pix  ur;
        t_pix  ll;
        t_pix  lr;
        t_ncnt nx;
        t_ncnt ny;
    } t_job;

    // fraction of a sample above its cell base, clamped to [0, 1]
    function automatic logic [FRAC:0] frac_of(input t_pos p, input t_cnt base);
        logic [POS_W:0] b;
        logic [POS_W:0] d;
        logic [FRAC:0]  f;
        b = (POS_W+1)'({base, {FRAC{1'b0}}});
        d = {1'b0, p} - b;
        if ({1'b0, p} <= b) begin
            f = '0;
        end else if (d > (POS_W+1)'(ONE_FIX)) begin
            f = ONE_FIX;
        end else begin
            f = d[FRAC:0];
        end
        return f;
    endfunction

endpackage

[sv/bilinear_image_resize.sv]
// channel  dir  handshake              payload
// s        in   i_s_tvalid/o_s_tready  tdata: chan0, chan1, chan2; tuser: frame_start
// m        out  o_m_tvalid/i_m_tready  tdata: out_x, out_y, out_chan0..2; tlast: run_last
// cfg      in   i_cfg_we               i_cfg_addr, i_cfg_data
//
// each source beat passes the front states in order (accept, line buffer read, cell span)
// each result passes the back states in order (horizontal blend, vertical blend, output beat)
// and each cell first passes the back's idle state, which takes it off the queue
// a 4-entry cell queue lets the front take new beats while the back works off results
// synchronous active-low reset clears the front counters, both sequencers and the queue; the line buffer is not cleared
// a stalled output holds the back only; the front stalls when the queue is full
module bilinear_image_resize
    import bir_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [23:0]      i_s_tdata,   // chan0, chan1, chan2
    input  logic             i_s_tuser,   // frame_start
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [47:0]      o_m_tdata,   // out_x, out_y, out_chan0, out_chan1, out_chan2
    output logic             o_m_tlast,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [DIM_W-1:0] r_src_w, r_src_h, r_dst_w, r_dst_h;
    t_step            r_step_x, r_step_y;
    t_cfg             w_cfg;
    t_job             w_job_in, w_job_out;
    logic             w_job_valid, w_full, w_empty, w_pop;

    function automatic t_cnt clamp_dim(input logic [DIM_W-1:0] v, input t_cnt top);
        t_cnt e;
        e = CNT_W'(v);
        if (e < CNT_W'(2)) begin
            e = CNT_W'(2);
        end else if (e > top) begin
            e = top;
        end
        return e;
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= DIM_W'(640);
            r_src_h  <= DIM_W'(480);
            r_dst_w  <= DIM_W'(640);
            r_dst_h  <= DIM_W'(480);
            r_step_x <= STEP_W'(65536);
            r_step_y <= STEP_W'(65536);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SRC_W:  r_src_w  <= i_cfg_data[DIM_W-1:0];
                REG_SRC_H:  r_src_h  <= i_cfg_data[DIM_W-1:0];
                REG_DST_W:  r_dst_w  <= i_cfg_data[DIM_W-1:0];
                REG_DST_H:  r_dst_h  <= i_cfg_data[DIM_W-1:0];
                REG_STEP_X: r_step_x <= i_cfg_data[STEP_W-1:0];
                REG_STEP_Y: r_step_y <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // effective dimensions
    always_comb begin
        w_cfg.src_w  = clamp_dim(r_src_w, CNT_W'(MAX_WIDTH));
        w_cfg.src_h  = clamp_dim(r_src_h, CNT_W'(MAX_HEIGHT));
        w_cfg.dst_w  = clamp_dim(r_dst_w, CNT_W'(MAX_WIDTH));
        w_cfg.dst_h  = clamp_dim(r_dst_h, CNT_W'(MAX_HEIGHT));
        w_cfg.step_x = r_step_x;
        w_cfg.step_y = r_step_y;
    end

    bir_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_pix         (i_s_tdata),
        .i_frame_start (i_s_tuser),
        .o_job_valid   (w_job_valid),
        .i_job_ready   (!w_full),
        .o_job         (w_job_in)
    );

    bir_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_valid),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_empty (w_empty)
    );

    bir_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_job_valid (!w_empty),
        .o_job_pop   (w_pop),
        .i_job       (w_job_out),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata),
        .o_last      (o_m_tlast)
    );

endmodule

[sv/bir_ram.sv]
module bir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/bir_fifo.sv]
module bir_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

[sv/bir_front.sv]
module bir_front
    import bir_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_pix   i_pix,
    input  logic   i_frame_start,
    output logic   o_job_valid,
    input  logic   i_job_ready,
    output t_job   o_job
);

    localparam int AW = $clog2(MAX_WIDTH);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_READ = 3'b010,
        F_SPAN = 3'b100
    } t_fstate;

    t_fstate r_state, n_state;
    t_cnt    r_col, n_col, r_row, n_row;
    t_cnt    r_c, n_c, r_r, n_r;
    t_pix    r_pix, n_pix, r_left, n_left, r_ul, n_ul;
    t_cnt    r_row_first, n_row_first, r_col_first, n_col_first;
    t_pos    r_row_pos, n_row_pos, r_col_pos, n_col_pos;
    t_pix    w_ur;
    logic    w_we;

    // number of destination positions that fall in the cell ending at edge
    function automatic t_ncnt span(input t_cnt first, input t_pos pos, input t_step step,
                                   input t_cnt target, input t_cnt edge_pos, input logic last);
        logic                 run;
        logic                 ok;
        t_ncnt                n;
        logic [POS_W+3:0]     p;
        logic [POS_W+3:0]     limit;
        n     = '0;
        run   = 1'b1;
        limit = (POS_W+4)'({edge_pos, {FRAC{1'b0}}});
        for (int k = 0; k < CELL_N; k++) begin
            p  = (POS_W+4)'(pos) + (POS_W+4)'(step) * (POS_W+4)'(k);
            ok = ((CNT_W+1)'(first) + (CNT_W+1)'(k) < (CNT_W+1)'(target))
                 && (last || (p < limit));
            if (run && ok) begin
                n = n + 1'b1;
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

    // line buffer with the previous source row
    bir_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (r_c[AW-1:0]),
        .i_wr_data (r_pix),
        .i_rd_addr (r_c[AW-1:0]),
        .o_rd_data (w_ur)
    );

    // cell classification
    logic  w_cell, w_last_c, w_last_r, w_push, w_go;
    t_ncnt w_nx, w_ny;
    t_cnt  w_col0, w_row0, w_col1, w_row1, w_nc, w_nr;
    logic  w_restart;

    assign w_cell   = (r_c != '0) && (r_r != '0);
    assign w_last_c = (r_c == i_cfg.src_w - 1'b1);
    assign w_last_r = (r_r == i_cfg.src_h - 1'b1);
    assign w_nx = w_cell ? span(r_col_first, r_col_pos, i_cfg.step_x, i_cfg.dst_w, r_c, w_last_c)
                         : '0;
    assign w_ny = w_cell ? span(r_row_first, r_row_pos, i_cfg.step_y, i_cfg.dst_h, r_r, w_last_r)
                         : '0;
    assign w_push = w_cell && (w_nx != '0) && (w_ny != '0);
    assign w_go   = !w_push || i_job_ready;
    assign w_we   = (r_state == F_SPAN) && w_go;

    assign o_ready     = (r_state == F_IDLE);
    assign o_job_valid = (r_state == F_SPAN) && w_push;

    always_comb begin
        o_job.base_x    = r_c - 1'b1;
        o_job.base_y    = r_r - 1'b1;
        o_job.col_first = r_col_first;
        o_job.row_first = r_row_first;
        o_job.col_pos   = r_col_pos;
        o_job.row_pos   = r_row_pos;
        o_job.ul        = r_ul;
        o_job.ur        = w_ur;
        o_job.ll        = r_left;
        o_job.lr        = r_pix;
        o_job.nx        = w_nx;
        o_job.ny        = w_ny;
    end

    // position of the arriving pixel
    always_comb begin
        w_col0    = i_frame_start ? '0 : r_col;
        w_row0    = i_frame_start ? '0 : r_row;
        w_col1    = w_col0;
        w_row1    = w_row0;
        w_restart = i_frame_start;
        if (w_col0 >= i_cfg.src_w) begin
            w_col1 = '0;
            w_row1 = w_row0 + 1'b1;
        end
        if (w_row1 >= i_cfg.src_h) begin
            w_col1    = '0;
            w_row1    = '0;
            w_restart = 1'b1;
        end
        w_nc = r_c + 1'b1;
        w_nr = r_r + 1'b1;
    end

    // sequencer and position state
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_c         = r_c;
        n_r         = r_r;
        n_pix       = r_pix;
        n_left      = r_left;
        n_ul        = r_ul;
        n_row_first = r_row_first;
        n_row_pos   = r_row_pos;
        n_col_first = r_col_first;
        n_col_pos   = r_col_pos;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_c   = w_col1;
                    n_r   = w_row1;
                    n_pix = i_pix;
                    if (w_restart) begin
                        n_row_first = '0;
                        n_row_pos   = '0;
                    end
                    if (w_restart || (w_col1 == '0)) begin
                        n_col_first = '0;
                        n_col_pos   = '0;
                    end
                    n_state = F_READ;
                end
            end
            F_READ: begin
                n_state = F_SPAN;
            end
            F_SPAN: begin
                if (w_go) begin
                    n_ul   = w_ur;
                    n_left = r_pix;
                    if (w_cell) begin
                        n_col_first = r_col_first + CNT_W'(w_nx);
                        n_col_pos   = r_col_pos + POS_W'(w_nx) * POS_W'(i_cfg.step_x);
                    end
                    if (w_last_c && (r_r != '0)) begin
                        n_row_first = r_row_first + CNT_W'(w_ny);
                        n_row_pos   = r_row_pos + POS_W'(w_ny) * POS_W'(i_cfg.step_y);
                    end
                    n_col = w_nc;
                    n_row = r_r;
                    if (w_nc >= i_cfg.src_w) begin
                        n_col = '0;
                        n_row = w_nr;
                        if (w_nr >= i_cfg.src_h) begin
                            n_row       = '0;
                            n_row_first = '0;
                            n_row_pos   = '0;
                            n_col_first = '0;
                            n_col_pos   = '0;
                        end
                    end
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_c         <= '0;
            r_r         <= '0;
            r_left      <= '0;
            r_ul        <= '0;
            r_row_first <= '0;
            r_row_pos   <= '0;
            r_col_first <= '0;
            r_col_pos   <= '0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_c         <= n_c;
            r_r         <= n_r;
            r_left      <= n_left;
            r_ul        <= n_ul;
            r_row_first <= n_row_first;
            r_row_pos   <= n_row_pos;
            r_col_first <= n_col_first;
            r_col_pos   <= n_col_pos;
        end
        r_pix <= n_pix;
    end

endmodule

[sv/bir_back.sv]
module bir_back
    import bir_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_job_valid,
    output logic        o_job_pop,
    input  t_job        i_job,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [47:0] o_data,
    output logic        o_last
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_HORZ = 4'b0010,
        B_VERT = 4'b0100,
        B_OUT  = 4'b1000
    } t_bstate;

    t_bstate      r_state;
    t_job         r_job;
    t_ncnt        r_i, r_j;
    t_pos         r_xpos, r_ypos;
    logic [24:0]  r_top [3];
    logic [24:0]  r_bot [3];
    logic [FRAC:0] r_fy;
    logic [47:0]  r_data;
    logic         r_last;

    logic [FRAC:0] w_fx, w_fy;
    logic [24:0]   w_top [3];
    logic [24:0]   w_bot [3];
    logic [39:0]   w_mix [3];
    logic          w_last_j, w_last_i;

    assign w_fx     = frac_of(r_xpos, r_job.base_x);
    assign w_fy     = frac_of(r_ypos, r_job.base_y);
    assign w_last_j = (r_j == r_job.nx - 1'b1);
    assign w_last_i = (r_i == r_job.ny - 1'b1);

    // per channel horizontal and vertical blends
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_top[ch] = 25'(r_job.ul[ch*8 +: 8]) * 25'(ONE_FIX - w_fx)
                      + 25'(r_job.ur[ch*8 +: 8]) * 25'(w_fx);
            w_bot[ch] = 25'(r_job.ll[ch*8 +: 8]) * 25'(ONE_FIX - w_fx)
                      + 25'(r_job.lr[ch*8 +: 8]) * 25'(w_fx);
            w_mix[ch] = 40'(r_top[ch]) * 40'(ONE_FIX - r_fy)
                      + 40'(r_bot[ch]) * 40'(r_fy);
        end
    end

    assign o_job_pop = (r_state == B_IDLE) && i_job_valid;
    assign o_valid   = (r_state == B_OUT);
    assign o_data    = r_data;
    assign o_last    = r_last;

    // result sequencer over the cell, row-major
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= B_HORZ;
                    end
                end
                B_HORZ: r_state <= B_VERT;
                B_VERT: r_state <= B_OUT;
                B_OUT: begin
                    if (i_ready) begin
                        r_state <= (w_last_j && w_last_i) ? B_IDLE : B_HORZ;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_job  <= i_job;
                r_i    <= '0;
                r_j    <= '0;
                r_xpos <= i_job.col_pos;
                r_ypos <= i_job.row_pos;
            end
            B_HORZ: begin
                for (int ch = 0; ch < 3; ch++) begin
                    r_top[ch] <= w_top[ch];
                    r_bot[ch] <= w_bot[ch];
                end
                r_fy <= w_fy;
            end
            B_VERT: begin
                r_data <= {2'b00, w_mix[2][39:32], w_mix[1][39:32], w_mix[0][39:32],
                           11'(r_job.row_first + CNT_W'(r_i)),
                           11'(r_job.col_first + CNT_W'(r_j))};
                r_last <= w_last_j && w_last_i;
            end
            B_OUT: begin
                if (i_ready) begin
                    if (!w_last_j) begin
                        r_j    <= r_j + 1'b1;
                        r_xpos <= r_xpos + POS_W'(i_cfg.step_x);
                    end else begin
                        r_j    <= '0;
                        r_i    <= r_i + 1'b1;
                        r_xpos <= r_job.col_pos;
                        r_ypos <= r_ypos + POS_W'(i_cfg.step_y);
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

[tb/sv/bilinear_image_resize_tb.sv]
`timescale 1ns / 1ps

module bilinear_image_resize_tb
    import bir_pkg::*;
;

    localparam int MAX_DIM       = 2048;
    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam longint unsigned UNIT = 64'd1 << FRAC;

    typedef struct {
        logic [10:0] x;
        logic [10:0] y;
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic        last;
    } t_resized_pix;

    // clock and dut ports
    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [23:0]      i_s_tdata = '0;   // chan0, chan1, chan2
    logic             i_s_tuser = 1'b0; // frame_start
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [47:0]      o_m_tdata;        // out_x, out_y, out_chan0, out_chan1, out_chan2
    logic             o_m_tlast;
    logic             i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    always #10 i_clk = ~i_clk;

    bilinear_image_resize dut (.*);

    // shadow of the scaler state
    logic [20:0]     scale_regs [6];
    logic [23:0]     row_above [MAX_DIM];
    logic [23:0]     left_pix, above_left_pix;
    int unsigned     src_col, src_row, row_first, col_first;
    longint unsigned row_pos, col_pos;

    t_resized_pix    resized_q[$];
    int              mismatches = 0;
    int              pixels_sent = 0;
    int              results_seen = 0;
    int              max_per_pixel = 0;
    bit              gaps_on = 1'b0;
    int              hold_off = 0;
    int              quiet_cycles = 0;

    function automatic int unsigned clamp_dim(logic [20:0] v);
        if (v < 2) return 2;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    // destination positions falling in the cell that ends at bound
    function automatic int unsigned cell_span(int unsigned first, longint unsigned pos,
            int unsigned step, int unsigned tgt, int unsigned bound, bit last_cell);
        int unsigned n;
        n = 0;
        while (n < CELL_N && first + n < tgt &&
               (last_cell || pos + longint'(n) * step < (longint'(bound) << FRAC)))
            n++;
        return n;
    endfunction

    function automatic longint unsigned frac_above(longint unsigned p, int unsigned base);
        longint unsigned b;
        b = longint'(base) << FRAC;
        if (p <= b) return 0;
        if (p - b > UNIT) return UNIT;
        return p - b;
    endfunction

    function automatic logic [7:0] blend_chan(logic [23:0] ul, logic [23:0] ur,
            logic [23:0] ll, logic [23:0] lr, int sh, longint unsigned fx,
            longint unsigned fy);
        longint unsigned a, b, c, d, hi, lo, sum;
        a = (ul >> sh) & 8'hff;
        b = (ur >> sh) & 8'hff;
        c = (ll >> sh) & 8'hff;
        d = (lr >> sh) & 8'hff;
        hi = a * (UNIT - fx) + b * fx;
        lo = c * (UNIT - fx) + d * fx;
        sum = (hi * (UNIT - fy) + lo * fy) >> (2 * FRAC);
        return sum[7:0];
    endfunction

    function automatic void restart_frame();
        src_col = 0; src_row = 0;
        row_first = 0; row_pos = 0;
        col_first = 0; col_pos = 0;
    endfunction

    // expected results caused by one accepted source pixel
    function automatic void predict_resize(logic [23:0] pix, logic fs);
        int unsigned w, h, tw, th, sx, sy, c, r, ny, nx, cnt, k;
        logic [23:0] ur;
        longint unsigned fx, fy;
        t_resized_pix o;
        w = clamp_dim(21'(scale_regs[REG_SRC_W][DIM_W-1:0]));
        h = clamp_dim(21'(scale_regs[REG_SRC_H][DIM_W-1:0]));
        tw = clamp_dim(21'(scale_regs[REG_DST_W][DIM_W-1:0]));
        th = clamp_dim(21'(scale_regs[REG_DST_H][DIM_W-1:0]));
        sx = scale_regs[REG_STEP_X];
        sy = scale_regs[REG_STEP_Y];
        ny = 0; nx = 0; k = 0;
        if (fs) restart_frame();
        if (src_col >= w) begin
            src_col = 0;
            src_row++;
        end
        if (src_row >= h) restart_frame();
        if (src_col == 0) begin
            col_first = 0;
            col_pos = 0;
        end
        c = src_col;
        r = src_row;
        ur = row_above[c];
        if (c >= 1 && r >= 1) begin
            ny = cell_span(row_first, row_pos, sy, th, r, r == h - 1);
            nx = cell_span(col_first, col_pos, sx, tw, c, c == w - 1);
            cnt = nx * ny;
            for (int unsigned i = 0; i < ny; i++) begin
                fy = frac_above(row_pos + longint'(i) * sy, r - 1);
                for (int unsigned j = 0; j < nx; j++) begin
                    fx = frac_above(col_pos + longint'(j) * sx, c - 1);
                    o.x = 11'(col_first + j);
                    o.y = 11'(row_first + i);
                    o.c0 = blend_chan(above_left_pix, ur, left_pix, pix, 0, fx, fy);
                    o.c1 = blend_chan(above_left_pix, ur, left_pix, pix, 8, fx, fy);
                    o.c2 = blend_chan(above_left_pix, ur, left_pix, pix, 16, fx, fy);
                    o.last = (k == cnt - 1);
                    resized_q.push_back(o);
                    k++;
                end
            end
            if (cnt > max_per_pixel) max_per_pixel = cnt;
            col_first += nx;
            col_pos += longint'(nx) * sx;
        end
        above_left_pix = ur;
        row_above[c] = pix;
        left_pix = pix;
        if (c == w - 1 && r >= 1) begin
            row_first += ny;
            row_pos += longint'(ny) * sy;
        end
        src_col++;
        if (src_col >= w) begin
            src_col = 0;
            src_row++;
            if (src_row >= h) restart_frame();
        end
    endfunction

    // one register write
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [20:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        scale_regs[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(int sw, int sh, int dw, int dh, int stx, int sty);
        write_reg(REG_SRC_W, 21'(sw));
        write_reg(REG_SRC_H, 21'(sh));
        write_reg(REG_DST_W, 21'(dw));
        write_reg(REG_DST_H, 21'(dh));
        write_reg(REG_STEP_X, 21'(stx));
        write_reg(REG_STEP_Y, 21'(sty));
    endtask

    // one source beat; valid stays up unless a gap follows
    task automatic send_pixel(logic [23:0] pix, logic fs);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= pix;
        i_s_tuser <= fs;
        do @(posedge i_clk); while (!o_s_tready);
        predict_resize(pix, fs);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // sender pauses until every result is back and the front has settled
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (resized_q.size() > 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_frame(int w, int h);
        for (int i = 0; i < w * h; i++) send_pixel(24'($urandom), i == 0);
    endtask

    // whole coordinates, half steps and channel extremes on a 2x2 source
    task automatic test_corner_pixels();
        set_geometry(2, 2, 3, 3, 32768, 32768);
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'hffffff, 1'b0);
        send_pixel(24'h00ff00, 1'b0);
        send_pixel(24'hff00ff, 1'b0);
        send_pixel(24'h5aa5c3, 1'b1);
        send_pixel(24'ha55a3c, 1'b0);
        send_pixel(24'hffffff, 1'b0);
        send_pixel(24'h000000, 1'b0);
        wait_drained();
    endtask

    // last cell takes at most eight columns and rows, the rest is dropped
    task automatic test_crowded_cells();
        set_geometry(0, 2, 4095, 2048, 65536, 65536);
        send_pixel(24'h102030, 1'b1);
        send_pixel(24'hf0e0d0, 1'b0);
        send_pixel(24'h7f807f, 1'b0);
        send_pixel(24'h010203, 1'b0);
        wait_drained();
        set_geometry(2, 2, 8, 8, 9363, 9363);
        send_frame(2, 2);
        wait_drained();
    endtask

    // widest source and steepest step, then a shrink in the middle of a row
    task automatic test_wide_and_shrink();
        set_geometry(2048, 2048, 2, 2, 1048576, 1048576);
        for (int i = 0; i < 6; i++) send_pixel(24'($urandom), i == 0);
        wait_drained();
        write_reg(REG_SRC_W, 21'd4);
        write_reg(REG_SRC_H, 21'd2);
        write_reg(REG_DST_W, 21'd4);
        write_reg(REG_DST_H, 21'd3);
        write_reg(REG_STEP_X, 21'd65536);
        write_reg(REG_STEP_Y, 21'd32768);
        for (int i = 0; i < 4; i++) send_pixel(24'($urandom), 1'b0);
        wait_drained();
    endtask

    // random geometry, mostly whole frames, some cut short or restarted
    task automatic test_random_frames(int n_items, bit gaps, int hold);
        int sw, sh, dw, dh, stx, sty, start, len;
        sw = $urandom_range(2, 10);
        sh = $urandom_range(2, 6);
        dw = $urandom_range(2, (7 * (sw - 1) + 1 < 20) ? 7 * (sw - 1) + 1 : 20);
        dh = $urandom_range(2, (7 * (sh - 1) + 1 < 14) ? 7 * (sh - 1) + 1 : 14);
        stx = ((sw - 1) << FRAC) / (dw - 1);
        sty = ((sh - 1) << FRAC) / (dh - 1);
        if ($urandom_range(0, 9) == 0) stx = $urandom_range(9363, 1048576);
        if ($urandom_range(0, 9) == 0) sty = $urandom_range(9363, 1048576);
        if (stx < 9363) stx = 9363;
        if (sty < 9363) sty = 9363;
        set_geometry(sw, sh, dw, dh, stx, sty);
        gaps_on = gaps;
        hold_off = hold;
        start = pixels_sent;
        while (pixels_sent - start < n_items) begin
            if ($urandom_range(0, 7) == 0) begin
                len = $urandom_range(1, sw * sh + 3);
                // a new geometry always begins with a fresh frame
                for (int i = 0; i < len; i++)
                    send_pixel(24'($urandom), (pixels_sent == start) ||
                               ($urandom_range(0, 9) == 0));
            end else begin
                send_frame(sw, sh);
            end
        end
        wait_drained();
        gaps_on = 1'b0;
    endtask

    // output ready, with random stalls and a long hold-off on request
    always @(negedge i_clk) begin
        logic rdy;
        int   stall_left;
        rdy = 1'b1;
        if (hold_off > 0) begin
            hold_off--;
            rdy = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            rdy = 1'b0;
        end
        i_m_tready <= rdy;
    end

    // compare each result beat with the oldest expected pixel
    always @(posedge i_clk) begin
        t_resized_pix got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.x = o_m_tdata[10:0];
            got.y = o_m_tdata[21:11];
            got.c0 = o_m_tdata[29:22];
            got.c1 = o_m_tdata[37:30];
            got.c2 = o_m_tdata[45:38];
            got.last = o_m_tlast;
            results_seen++;
            if (resized_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d", got.x, got.y);
            end else begin
                want = resized_q.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.c0 !== want.c0 ||
                    got.c1 !== want.c1 || got.c2 !== want.c2 || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp x=%0d y=%0d %h %h %h l=%b ",
                                  "got x=%0d y=%0d %h %h %h l=%b"},
                                 want.x, want.y, want.c0, want.c1, want.c2, want.last,
                                 got.x, got.y, got.c0, got.c1, got.c2, got.last);
                end
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we ||
            !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no progress, %0d results outstanding", resized_q.size());
            $display("** bilinear_image_resize: FAILED **");
            $finish;
        end
    end

    initial begin
        scale_regs = '{21'd640, 21'd480, 21'd640, 21'd480, 21'd65536, 21'd65536};
        left_pix = '0;
        above_left_pix = '0;
        restart_frame();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_pixels();
        test_crowded_cells();
        test_wide_and_shrink();
        test_random_frames(60, 1'b1, 400);
        for (int p = 0; p < 4; p++) test_random_frames(65, 1'b1, 0);
        test_random_frames(40, 1'b0, 0);
        if (resized_q.size() > 0) mismatches++;
        $display("sent %0d source pixels, checked %0d resized pixels (up to %0d per pixel)",
                 pixels_sent, results_seen, max_per_pixel);
        $display("geometries: corner cases, crowded cells, shrink mid-row, random frames");
        if (mismatches == 0) begin
            $display("** bilinear_image_resize: PASSED **");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("** bilinear_image_resize: FAILED **");
        end
        $finish;
    end

endmodule
